// ----- rtl/core/pe_pkg.sv -----
// Shared types, constants and saturation helpers for the polynomial evaluator.
package pe_pkg;

    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * Q_W;
    localparam int SHIFT_W    = PROD_W - FRAC_W;
    localparam int COEF_REGS  = 8;
    localparam int COEF_IDX_W = 3;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd32768);
    localparam logic signed [Q_W-1:0]    Q_MAX      = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]    Q_MIN      = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [COEF_REGS-1:0][Q_W-1:0] coef_bank_t;

    typedef struct packed {
        logic         valid;
        logic         ovf;
        logic [Q_W-1:0] acc;
        logic [Q_W-1:0] x;
    } pe_item_t;

    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] value;
    } sat_t;

    function automatic sat_t sat_shifted(input logic signed [SHIFT_W-1:0] v);
        sat_t r;
        if (v[SHIFT_W-1:Q_W-1] == {(SHIFT_W-Q_W+1){v[SHIFT_W-1]}})
        begin
            r.ovf   = 1'b0;
            r.value = v[Q_W-1:0];
        end
        else
        begin
            r.ovf   = 1'b1;
            r.value = v[SHIFT_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic sat_t sat_sum(input logic signed [Q_W:0] v);
        sat_t r;
        if (v[Q_W] == v[Q_W-1])
        begin
            r.ovf   = 1'b0;
            r.value = v[Q_W-1:0];
        end
        else
        begin
            r.ovf   = 1'b1;
            r.value = v[Q_W] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pe_coef_bank.sv -----
// Coefficient register bank written through the configuration port.
module pe_coef_bank
    import pe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [COEF_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]        cfg_data,
    output coef_bank_t            coefs
);

    coef_bank_t coef_reg;
    coef_bank_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            coef_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

// ----- rtl/core/pe_horner_step.sv -----
// One Horner step in three stages: multiply, round and saturate, add coefficient and saturate.
module pe_horner_step
    import pe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pe_item_t item_in,
    input  q_t       coef,
    output pe_item_t item_out
);

    logic                     mul_valid_reg;
    logic                     mul_ovf_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;
    logic [Q_W-1:0]           mul_x_reg;
    logic signed [PROD_W-1:0] mul_prod_next;

    pe_item_t                 rnd_reg;
    pe_item_t                 rnd_next;
    logic signed [PROD_W-1:0] rounded;
    sat_t                     rnd_sat;

    pe_item_t                 add_reg;
    pe_item_t                 add_next;
    logic signed [Q_W:0]      sum;
    sat_t                     add_sat;

    assign mul_prod_next = $signed(item_in.acc) * $signed(item_in.x);

    always_comb
    begin
        rounded        = mul_prod_reg + ROUND_HALF;
        rnd_sat        = sat_shifted(rounded[PROD_W-1:FRAC_W]);
        rnd_next.valid = mul_valid_reg;
        rnd_next.ovf   = mul_ovf_reg | rnd_sat.ovf;
        rnd_next.acc   = rnd_sat.value;
        rnd_next.x     = mul_x_reg;
    end

    always_comb
    begin
        sum            = {rnd_reg.acc[Q_W-1], rnd_reg.acc} + {coef[Q_W-1], coef};
        add_sat        = sat_sum(sum);
        add_next.valid = rnd_reg.valid;
        add_next.ovf   = rnd_reg.ovf | add_sat.ovf;
        add_next.acc   = add_sat.value;
        add_next.x     = rnd_reg.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            mul_ovf_reg   <= 1'b0;
            mul_prod_reg  <= '0;
            mul_x_reg     <= '0;
            rnd_reg       <= '0;
            add_reg       <= '0;
        end
        else
        begin
            mul_valid_reg <= item_in.valid;
            mul_ovf_reg   <= item_in.ovf;
            mul_prod_reg  <= mul_prod_next;
            mul_x_reg     <= item_in.x;
            rnd_reg       <= rnd_next;
            add_reg       <= add_next;
        end
    end

    assign item_out = add_reg;

endmodule

// ----- rtl/core/polynomial_evaluator_top.sv -----
// Top level of the pipelined Horner polynomial evaluator.
// The block takes one sample every cycle and busy stays low. Each result comes out on
// poly_value and overflow with done high for one cycle, after its item has passed the
// entry register and every Horner step; each step owns one 32 by 32 multiplier followed by a
// rounding stage and a coefficient adder stage. Results arrive in input order and cannot
// be held off by the receiver.
// Coefficients should be written only while no item is in flight.
module polynomial_evaluator_top
    import pe_pkg::*;
#(
    parameter int NUM_TERMS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [Q_W-1:0]        x_value,
    output logic [Q_W-1:0]        poly_value,
    output logic                  overflow,
    output logic                  done,
    input  logic                  cfg_write,
    input  logic [COEF_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]        cfg_data
);

    coef_bank_t coefs;
    pe_item_t   chain [NUM_TERMS];
    pe_item_t   entry_reg;
    pe_item_t   entry_next;

    pe_coef_bank u_coef_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    assign busy = 1'b0;

    always_comb
    begin
        entry_next.valid = start & ~busy;
        entry_next.ovf   = 1'b0;
        entry_next.acc   = coefs[NUM_TERMS-1];
        entry_next.x     = x_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign chain[0] = entry_reg;

    for (genvar j = 0; j < NUM_TERMS - 1; j++)
    begin : g_step
        localparam int K = NUM_TERMS - 2 - j;

        pe_horner_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .item_in  (chain[j]),
            .coef     (coefs[K]),
            .item_out (chain[j+1])
        );
    end

    assign done       = chain[NUM_TERMS-1].valid;
    assign overflow   = chain[NUM_TERMS-1].ovf;
    assign poly_value = chain[NUM_TERMS-1].acc;

endmodule

// ----- rtl/core/pe_checker.sv -----
// Port-level checks for the polynomial evaluator and their binding to the top level.
module pe_checker #(
    parameter int NUM_TERMS = 8
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] x_value,
    input logic [31:0] poly_value,
    input logic        overflow,
    input logic        done
);

    localparam int LAT = 1 + 3 * (NUM_TERMS - 1);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline accepts every cycle");

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item produced no result at the expected latency");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result appeared without a matching accepted item");

    a_zero_x_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && x_value == 32'd0, LAT)) |-> !overflow)
        else $error("overflow reported for a sample of zero");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({poly_value, overflow}))
        else $error("result carries unknown bits");

endmodule

bind polynomial_evaluator_top pe_checker #(.NUM_TERMS(NUM_TERMS)) u_pe_checker (.*);

// ----- tb/sv/polynomial_evaluator_top_tb.sv -----
// Self-checking testbench for the Horner polynomial evaluator top level.
module polynomial_evaluator_top_tb;
    import pe_pkg::*;

    localparam int TERMS         = 8;
    localparam int LATENCY       = 1 + 3 * (TERMS - 1);
    localparam int MAX_GAP       = 13;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_ITEMS   = 95;
    localparam int CYCLE_LIMIT   = 400000;
    localparam q_t ONE_Q         = 32'sh0001_0000;
    localparam q_t HALF_Q        = 32'sh0000_8000;

    typedef struct {
        q_t   value;
        logic ovf;
    } poly_result_t;

    typedef q_t coef_set_t [TERMS];

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [Q_W-1:0]        x_value;
    logic [Q_W-1:0]        poly_value;
    logic                  overflow;
    logic                  done;
    logic                  cfg_write;
    logic [COEF_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]        cfg_data;

    q_t           coef_shadow [TERMS];
    poly_result_t pending_results [$];
    int           error_count;
    int           cycle_count;
    bit           no_gaps;

    polynomial_evaluator_top #(
        .NUM_TERMS (TERMS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .poly_value (poly_value),
        .overflow   (overflow),
        .done       (done),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > longint'(Q_MAX))
        begin
            ovf = 1'b1;
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN))
        begin
            ovf = 1'b1;
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    function automatic poly_result_t horner_eval(input q_t x);
        poly_result_t r;
        longint       acc;
        longint       prod;
        bit           ovf;
        ovf = 1'b0;
        acc = longint'(coef_shadow[TERMS-1]);
        for (int k = TERMS - 2; k >= 0; k--)
        begin
            prod = acc * longint'(x) + 64'sd32768;
            acc  = clamp_q(prod >>> FRAC_W, ovf);
            acc  = clamp_q(acc + longint'(coef_shadow[k]), ovf);
        end
        r.value = q_t'(acc);
        r.ovf   = ovf;
        return r;
    endfunction

    function automatic q_t rand_x();
        case ($urandom_range(0, 9))
            0, 1:    return q_t'($urandom());
            2:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            3:       return q_t'($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
            default: return q_t'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_FFFF;
        endcase
    endfunction

    function automatic q_t rand_coef(input int family);
        int pick;
        pick = (family == 0) ? $urandom_range(0, 9) : family;
        case (pick)
            1:       return q_t'($urandom_range(0, 32'h0001_FFFF)) - 32'sh0000_FFFF;
            2:       return q_t'($urandom());
            3:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            4:       return '0;
            5:       return q_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh007F_FFFF;
            default: return q_t'($urandom_range(0, 32'h0007_FFFF)) - 32'sh0003_FFFF;
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        poly_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h/%b",
                         $time, poly_value, overflow);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (poly_value !== want.value)
                begin
                    $display("%0t poly_value mismatch: expected %h actual %h",
                             $time, want.value, poly_value);
                    error_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $display("%0t overflow mismatch: expected %b actual %b",
                             $time, want.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input q_t x);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        x_value <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(horner_eval(x));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_coefs(input coef_set_t vals);
        for (int i = 0; i < TERMS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= COEF_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            coef_shadow[i] = vals[i];
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_coefs();
        send_item(Q_MAX);
        send_item(Q_MIN);
        send_item('0);
        drain_results();
    endtask

    task automatic test_unit_coefs();
        coef_set_t vals;
        foreach (vals[i])
            vals[i] = ONE_Q;
        write_coefs(vals);
        send_item(ONE_Q);
        send_item(-ONE_Q);
        send_item(HALF_Q);
        send_item(Q_MAX);
        send_item(Q_MIN);
        drain_results();
    endtask

    task automatic test_round_half_up();
        coef_set_t vals;
        foreach (vals[i])
            vals[i] = '0;
        vals[1] = HALF_Q;
        write_coefs(vals);
        send_item(32'sd1);
        send_item(-32'sd1);
        send_item(32'sd3);
        send_item(-32'sd3);
        drain_results();
    endtask

    task automatic test_extreme_coefs();
        coef_set_t vals;
        foreach (vals[i])
            vals[i] = Q_MAX;
        write_coefs(vals);
        send_item(Q_MAX);
        send_item(Q_MIN);
        send_item('0);
        send_item(-32'sd1);
        drain_results();
        foreach (vals[i])
            vals[i] = Q_MIN;
        write_coefs(vals);
        send_item(Q_MAX);
        send_item(Q_MIN);
        send_item(ONE_Q);
        send_item(32'sd1);
        drain_results();
        foreach (vals[i])
            vals[i] = (i % 2 == 0) ? Q_MAX : Q_MIN;
        write_coefs(vals);
        send_item(-ONE_Q);
        send_item(ONE_Q);
        send_item(2 * ONE_Q);
        drain_results();
    endtask

    task automatic test_random_phases();
        coef_set_t vals;
        int        family;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            family = $urandom_range(0, 5);
            foreach (vals[i])
                vals[i] = rand_coef(family);
            write_coefs(vals);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_x());
            drain_results();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        x_value     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        no_gaps     = 1'b0;
        foreach (coef_shadow[i])
            coef_shadow[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_unit_coefs();
        test_round_half_up();
        test_extreme_coefs();
        test_random_phases();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
